FILE: hw/rtl/dd_pkg.sv
package dd_pkg;

    localparam int unsigned DAY_W   = 5;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned DNUM_W  = 23;
    localparam int unsigned DOFF_W  = 9;
    localparam int unsigned DIFF_W  = DNUM_W + 1;

    // floor(x / 100) == (x * RECIP_100) >> RECIP_SH for every x below 2**15
    localparam int unsigned RECIP_100 = 5243;
    localparam int unsigned RECIP_SH  = 19;

    localparam logic signed [DIFF_W-1:0] COUNT_MAX = 24'sd4194303;

    typedef enum logic [1:0] {
        ORD_EQUAL   = 2'b00,
        ORD_LATER   = 2'b01,
        ORD_EARLIER = 2'b11
    } t_order;

    typedef struct packed {
        logic [DNUM_W-1:0] day_num;
        logic              valid;
    } t_date_res;

    // Days in the months before the given month; out-of-range months keep counting.
    function automatic logic [DOFF_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
        logic [DOFF_W-1:0] v;
        case (m)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd0;
            4'd2:    v = 9'd31;
            4'd3:    v = 9'd59;
            4'd4:    v = 9'd90;
            4'd5:    v = 9'd120;
            4'd6:    v = 9'd151;
            4'd7:    v = 9'd181;
            4'd8:    v = 9'd212;
            4'd9:    v = 9'd243;
            4'd10:   v = 9'd273;
            4'd11:   v = 9'd304;
            4'd12:   v = 9'd334;
            4'd13:   v = 9'd365;
            4'd14:   v = 9'd395;
            default: v = 9'd425;
        endcase
        return v;
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] v;
        case (m)
            4'd2:    v = leap ? 5'd29 : 5'd28;
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: v = 5'd31;
            default: v = 5'd30;
        endcase
        return v;
    endfunction

endpackage

FILE: hw/rtl/dd_day_num.sv
module dd_day_num (
    input  logic                          i_clk,
    input  logic [dd_pkg::DAY_W-1:0]      i_day,
    input  logic [dd_pkg::MONTH_W-1:0]    i_month,
    input  logic [dd_pkg::YEAR_W-1:0]     i_year,
    output dd_pkg::t_date_res             o_res
);
    import dd_pkg::*;

    localparam int unsigned Y1_W = YEAR_W + 1;
    localparam int unsigned P_W  = Y1_W + 13;

    // stage A: reciprocal products
    logic [Y1_W-1:0]   w_yp99;
    logic [Y1_W-1:0]   w_yp399;
    logic [P_W-1:0]    w_p100;
    logic [P_W-1:0]    w_p99;
    logic [P_W-1:0]    w_p399;

    logic [DAY_W-1:0]   r_a_day;
    logic [MONTH_W-1:0] r_a_month;
    logic [YEAR_W-1:0]  r_a_year;
    logic [DNUM_W-1:0]  r_a_y365;
    logic [7:0]         r_a_q100;
    logic [7:0]         r_a_c100;
    logic [5:0]         r_a_c400;

    assign w_yp99  = Y1_W'(i_year) + Y1_W'(99);
    assign w_yp399 = (Y1_W'(i_year) + Y1_W'(399)) >> 2;
    assign w_p100  = P_W'(i_year) * P_W'(RECIP_100);
    assign w_p99   = P_W'(w_yp99) * P_W'(RECIP_100);
    assign w_p399  = P_W'(w_yp399) * P_W'(RECIP_100);

    always_ff @(posedge i_clk) begin
        r_a_day   <= i_day;
        r_a_month <= i_month;
        r_a_year  <= i_year;
        r_a_y365  <= DNUM_W'(i_year) * DNUM_W'(365);
        r_a_q100  <= 8'(w_p100 >> RECIP_SH);
        r_a_c100  <= 8'(w_p99 >> RECIP_SH);
        r_a_c400  <= 6'(w_p399 >> RECIP_SH);
    end

    // stage B: leap rule, year base, month offset, validity
    logic [YEAR_W-1:0] w_rem100;
    logic              w_leap;
    logic [DNUM_W-1:0] w_quarter;
    logic [DAY_W-1:0]  w_mlen;
    logic              w_valid;

    logic [DNUM_W-1:0] r_b_base;
    logic [DOFF_W:0]   r_b_moff;
    logic [DAY_W-1:0]  r_b_day;
    logic              r_b_valid;

    assign w_rem100  = r_a_year - YEAR_W'(r_a_q100) * YEAR_W'(100);
    assign w_leap    = (w_rem100 == '0) ? (r_a_q100[1:0] == 2'b00) : (r_a_year[1:0] == 2'b00);
    assign w_quarter = DNUM_W'((Y1_W'(r_a_year) + Y1_W'(3)) >> 2);
    assign w_mlen    = month_len(r_a_month, w_leap);
    assign w_valid   = (r_a_month >= 4'd1) && (r_a_month <= 4'd12)
                    && (r_a_day != '0) && (r_a_day <= w_mlen);

    always_ff @(posedge i_clk) begin
        r_b_base  <= r_a_y365 + w_quarter - DNUM_W'(r_a_c100) + DNUM_W'(r_a_c400);
        r_b_moff  <= (DOFF_W+1)'(days_before_month(r_a_month))
                   + (DOFF_W+1)'((r_a_month >= 4'd3) && w_leap);
        r_b_day   <= r_a_day;
        r_b_valid <= w_valid;
    end

    // stage C: final day number
    always_ff @(posedge i_clk) begin
        o_res.day_num <= r_b_base + DNUM_W'(r_b_moff) + DNUM_W'(r_b_day);
        o_res.valid   <= r_b_valid;
    end

endmodule

FILE: hw/rtl/date_difference_days.sv
// The result strobe follows the accepting edge through the day-number stages and the output register.
// Throughput: one transaction per cycle; busy stays low, the pipeline never stalls.
// Three stages per date (reciprocal products, leap/base sum, day number), one for
// the difference and saturation. Reset clears only the valid bits of the stages.
// The receiver cannot stall: each result appears for exactly one cycle.
module date_difference_days (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [dd_pkg::DAY_W-1:0]      i_first_day,
    input  logic [dd_pkg::MONTH_W-1:0]    i_first_month,
    input  logic [dd_pkg::YEAR_W-1:0]     i_first_year,
    input  logic [dd_pkg::DAY_W-1:0]      i_second_day,
    input  logic [dd_pkg::MONTH_W-1:0]    i_second_month,
    input  logic [dd_pkg::YEAR_W-1:0]     i_second_year,
    output logic                          o_strobe,
    output logic signed [1:0]             o_order,
    output logic signed [dd_pkg::DNUM_W-1:0] o_day_count,
    output logic                          o_first_valid,
    output logic                          o_second_valid
);
    import dd_pkg::*;

    logic      w_accept;
    t_order    w_order;
    t_date_res w_res1;
    t_date_res w_res2;

    logic [2:0] r_vld;
    t_order     r_ord [3];
    logic       r_out_vld;

    logic signed [DIFF_W-1:0] w_diff;
    logic signed [DIFF_W-1:0] w_count;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    always_comb begin
        if (i_first_year != i_second_year) begin
            w_order = (i_first_year > i_second_year) ? ORD_LATER : ORD_EARLIER;
        end else if (i_first_month != i_second_month) begin
            w_order = (i_first_month > i_second_month) ? ORD_LATER : ORD_EARLIER;
        end else if (i_first_day != i_second_day) begin
            w_order = (i_first_day > i_second_day) ? ORD_LATER : ORD_EARLIER;
        end else begin
            w_order = ORD_EQUAL;
        end
    end

    dd_day_num u_first (
        .i_clk   (i_clk),
        .i_day   (i_first_day),
        .i_month (i_first_month),
        .i_year  (i_first_year),
        .o_res   (w_res1)
    );

    dd_day_num u_second (
        .i_clk   (i_clk),
        .i_day   (i_second_day),
        .i_month (i_second_month),
        .i_year  (i_second_year),
        .o_res   (w_res2)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_vld     <= {r_vld[1:0], w_accept};
            r_out_vld <= r_vld[2];
        end
    end

    always_ff @(posedge i_clk) begin
        r_ord[0] <= w_order;
        r_ord[1] <= r_ord[0];
        r_ord[2] <= r_ord[1];
    end

    // subtract the earlier day number from the later one, clamp the top
    always_comb begin
        case (r_ord[2])
            ORD_LATER:   w_diff = $signed({1'b0, w_res1.day_num}) - $signed({1'b0, w_res2.day_num});
            ORD_EARLIER: w_diff = $signed({1'b0, w_res2.day_num}) - $signed({1'b0, w_res1.day_num});
            default:     w_diff = '0;
        endcase
        w_count = (w_diff > COUNT_MAX) ? COUNT_MAX : w_diff;
    end

    always_ff @(posedge i_clk) begin
        o_order        <= r_ord[2];
        o_day_count    <= w_count[DNUM_W-1:0];
        o_first_valid  <= w_res1.valid;
        o_second_valid <= w_res2.valid;
    end

    assign o_strobe = r_out_vld;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##4 o_strobe)
        else $error("result strobe missing four cycles after accept");

    a_equal_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_order == ORD_EQUAL) |-> (o_day_count == '0))
        else $error("equal dates gave a nonzero day count");

    a_count_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_day_count > -23'sd92))
        else $error("day count below the invalid-day floor");

    a_order_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_order != 2'b10))
        else $error("order carries an unused code");

endmodule

FILE: tb/date_difference_days_test.sv
`timescale 1ns / 1ps

module date_difference_days_test;
    import dd_pkg::*;

    localparam int RANDOM_PAIRS = 1630;
    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 10;

    typedef struct packed {
        logic [DAY_W-1:0]   d;
        logic [MONTH_W-1:0] m;
        logic [YEAR_W-1:0]  y;
    } t_date;

    typedef struct packed {
        t_date a;
        t_date b;
    } t_date_pair;

    typedef struct {
        t_order                   ord;
        logic signed [DNUM_W-1:0] cnt;
        logic                     v1;
        logic                     v2;
    } t_result;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic [DAY_W-1:0]         i_first_day = '0;
    logic [MONTH_W-1:0]       i_first_month = '0;
    logic [YEAR_W-1:0]        i_first_year = '0;
    logic [DAY_W-1:0]         i_second_day = '0;
    logic [MONTH_W-1:0]       i_second_month = '0;
    logic [YEAR_W-1:0]        i_second_year = '0;
    logic                     o_strobe;
    logic signed [1:0]        o_order;
    logic signed [DNUM_W-1:0] o_day_count;
    logic                     o_first_valid;
    logic                     o_second_valid;

    t_date_pair pending_pairs[$];
    t_result    awaited_results[$];
    t_result    got_expected;

    int n_sent = 0;
    int n_checked = 0;
    int n_errors = 0;
    int n_equal = 0;
    int n_invalid = 0;
    int n_saturated = 0;
    int n_negative = 0;
    int burst_left = 1;
    int gap_left = 0;
    int idle_cycles = 0;

    date_difference_days u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_first_day    (i_first_day),
        .i_first_month  (i_first_month),
        .i_first_year   (i_first_year),
        .i_second_day   (i_second_day),
        .i_second_month (i_second_month),
        .i_second_year  (i_second_year),
        .o_strobe       (o_strobe),
        .o_order        (o_order),
        .o_day_count    (o_day_count),
        .o_first_valid  (o_first_valid),
        .o_second_valid (o_second_valid)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic bit leap_year(int unsigned y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    // serial_day passes a cleared leap flag and adds the leap day on its own.
    function automatic int unsigned days_in_month(int unsigned m, bit leap);
        case (m)
            2: return leap ? 29 : 28;
            1, 3, 5, 7, 8, 10, 12: return 31;
            default: return 30;
        endcase
    endfunction

    function automatic int serial_day(t_date x);
        int unsigned y;
        int          n;
        y = x.y;
        n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
        // months 13 and 14 count as 30 days, so month 15 keeps accumulating
        for (int unsigned k = 1; k < x.m; k++) begin
            n += days_in_month(k, 1'b0);
        end
        if (x.m >= 3 && leap_year(y)) begin
            n += 1;
        end
        return n + x.d;
    endfunction

    function automatic bit date_ok(t_date x);
        if (x.m < 1 || x.m > 12) return 1'b0;
        return (x.d >= 1) && (x.d <= days_in_month(x.m, leap_year(x.y)));
    endfunction

    function automatic t_result predict_difference(t_date_pair p);
        t_result r;
        int      diff;
        diff  = 0;
        r.ord = ORD_EQUAL;
        if ({p.a.y, p.a.m, p.a.d} > {p.b.y, p.b.m, p.b.d}) begin
            r.ord = ORD_LATER;
            diff  = serial_day(p.a) - serial_day(p.b);
        end else if ({p.a.y, p.a.m, p.a.d} < {p.b.y, p.b.m, p.b.d}) begin
            r.ord = ORD_EARLIER;
            diff  = serial_day(p.b) - serial_day(p.a);
        end
        if (diff > COUNT_MAX) begin
            diff = COUNT_MAX;
        end
        r.cnt = diff[DNUM_W-1:0];
        r.v1  = date_ok(p.a);
        r.v2  = date_ok(p.b);
        return r;
    endfunction

    function automatic t_date make_date(int unsigned d, int unsigned m, int unsigned y);
        t_date x;
        x.d = DAY_W'(d);
        x.m = MONTH_W'(m);
        x.y = YEAR_W'(y);
        return x;
    endfunction

    function automatic t_date random_valid_date();
        int unsigned y;
        int unsigned m;
        y = $urandom_range(1, 9999);
        m = $urandom_range(1, 12);
        return make_date($urandom_range(1, days_in_month(m, leap_year(y))), m, y);
    endfunction

    function automatic t_date random_raw_date();
        return make_date($urandom, $urandom, $urandom);
    endfunction

    function automatic int unsigned corner_year();
        case ($urandom_range(0, 12))
            0:  return 0;
            1:  return 1;
            2:  return 4;
            3:  return 100;
            4:  return 400;
            5:  return 1600;
            6:  return 1900;
            7:  return 2000;
            8:  return 2100;
            9:  return 9999;
            10: return 10000;
            11: return 12000;
            default: return 16383;
        endcase
    endfunction

    task automatic add_pair(int unsigned d1, int unsigned m1, int unsigned y1,
                            int unsigned d2, int unsigned m2, int unsigned y2);
        t_date_pair p;
        p.a = make_date(d1, m1, y1);
        p.b = make_date(d2, m2, y2);
        pending_pairs.push_back(p);
    endtask

    // Driver: hold the current transaction until accepted, then advance.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                awaited_results.push_back(predict_difference(pending_pairs[0]));
                pending_pairs.delete(0);
                n_sent++;
            end
            if (!(start && busy)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (pending_pairs.size() == 0) begin
                    start <= 1'b0;
                end else begin
                    i_first_day    <= pending_pairs[0].a.d;
                    i_first_month  <= pending_pairs[0].a.m;
                    i_first_year   <= pending_pairs[0].a.y;
                    i_second_day   <= pending_pairs[0].b.d;
                    i_second_month <= pending_pairs[0].b.m;
                    i_second_year  <= pending_pairs[0].b.y;
                    start          <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 200)
                                                                 : $urandom_range(1, 8);
                        gap_left   = $urandom_range(0, 7);
                    end else begin
                        burst_left--;
                    end
                end
            end
        end
    end

    // Monitor: every strobe must match the oldest outstanding prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (awaited_results.size() == 0) begin
                $display("%0t: result with none outstanding: order %b count %0d valid %b%b",
                         $time, o_order, o_day_count, o_first_valid, o_second_valid);
                n_errors++;
            end else begin
                got_expected = awaited_results.pop_front();
                n_checked++;
                if (got_expected.ord == ORD_EQUAL) n_equal++;
                if (!got_expected.v1 || !got_expected.v2) n_invalid++;
                if (got_expected.cnt == COUNT_MAX[DNUM_W-1:0]) n_saturated++;
                if (got_expected.cnt < 0) n_negative++;
                if (o_order !== got_expected.ord) begin
                    $display("%0t: order expected %b actual %b",
                             $time, got_expected.ord, o_order);
                    n_errors++;
                end
                if (o_day_count !== got_expected.cnt) begin
                    $display("%0t: day_count expected %0d actual %0d",
                             $time, got_expected.cnt, o_day_count);
                    n_errors++;
                end
                if (o_first_valid !== got_expected.v1) begin
                    $display("%0t: first_valid expected %b actual %b",
                             $time, got_expected.v1, o_first_valid);
                    n_errors++;
                end
                if (o_second_valid !== got_expected.v2) begin
                    $display("%0t: second_valid expected %b actual %b",
                             $time, got_expected.v2, o_second_valid);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog: drop the run if no transaction moves for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_strobe) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
                $display("date_difference_days_test: FAIL");
                $finish;
            end
        end
    end

    initial begin
        t_date_pair p;
        int         pick;

        // equal dates, valid and not
        add_pair(15, 6, 2000, 15, 6, 2000);
        add_pair(0, 0, 0, 0, 0, 0);
        // all-ones against all-zeros: saturates in both directions
        add_pair(31, 15, 16383, 0, 0, 0);
        add_pair(0, 0, 0, 31, 15, 16383);
        // leap rules: divisible by 400, by 100 only, by 4
        add_pair(29, 2, 2000, 28, 2, 1900);
        add_pair(29, 2, 1900, 29, 2, 2004);
        add_pair(29, 2, 0, 1, 1, 1);
        // day past month end and day zero
        add_pair(31, 4, 2023, 1, 5, 2023);
        add_pair(0, 3, 2021, 1, 3, 2021);
        add_pair(1, 3, 2001, 31, 2, 2001);
        // most negative count: later date has the smaller day number
        add_pair(0, 1, 2, 31, 15, 1);
        // out-of-range months
        add_pair(1, 13, 2010, 1, 14, 2010);
        add_pair(20, 15, 2010, 5, 0, 2010);
        add_pair(10, 0, 2010, 10, 12, 2009);
        // year boundaries and the full valid span
        add_pair(31, 12, 9999, 1, 1, 1);
        add_pair(31, 12, 1999, 1, 1, 2000);
        add_pair(3, 7, 1987, 28, 7, 1987);
        add_pair(30, 2, 2024, 1, 3, 2024);
        add_pair(1, 1, 10000, 31, 12, 9999);
        add_pair(31, 12, 16383, 1, 1, 16383);

        repeat (RANDOM_PAIRS) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                p.a = random_valid_date();
                p.b = random_valid_date();
            end else if (pick < 60) begin
                p.b = random_valid_date();
                if ($urandom_range(0, 3) == 0) begin
                    p.a = p.b;
                end else begin
                    p.a   = random_valid_date();
                    p.a.y = p.b.y;
                    if ($urandom_range(0, 1) == 0) p.a.m = p.b.m;
                end
            end else if (pick < 75) begin
                p.a = random_raw_date();
                p.b = random_raw_date();
            end else if (pick < 90) begin
                p.a = make_date($urandom_range(0, 31), $urandom_range(0, 15), corner_year());
                p.b = make_date($urandom_range(0, 31), $urandom_range(0, 15), corner_year());
            end else begin
                p.a = random_valid_date();
                p.b = make_date($urandom_range(0, 31), $urandom_range(0, 15), p.a.y + 1);
            end
            if ($urandom_range(0, 1) == 0) begin
                pending_pairs.push_back(p);
            end else begin
                pending_pairs.push_back({p.b, p.a});
            end
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk);
        while (pending_pairs.size() != 0 || awaited_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Compared %0d of %0d date pairs: %0d equal, %0d with an invalid date,",
                 n_checked, n_sent, n_equal, n_invalid);
        $display("%0d saturated and %0d negative day counts; %0d mismatches",
                 n_saturated, n_negative, n_errors);
        if (n_errors == 0) begin
            $display("date_difference_days_test: PASS");
        end else begin
            $display("date_difference_days_test: FAIL");
        end
        $finish;
    end

endmodule
